// ----- src/ftmma_pkg.sv -----
// Package for the frame-time min/max/average block.
// Shared types, codes and default sizes; no dependencies.
`default_nettype none
package ftmma_pkg;

	localparam int unsigned MAX_WINDOW_DEF = 64;
	localparam int unsigned TIME_BITS_DEF  = 32;
	localparam int unsigned CFG_BITS       = 7;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIV,
		ST_EMIT
	} back_state_t;

	typedef struct packed {
		logic                we;
		logic [CFG_BITS-1:0] value;
	} cfg_t;

endpackage
`default_nettype wire

// ----- src/ftmma_in_if.sv -----
// Input channel of the frame-time block: valid/ready with operation and sample.
// Depends on nothing.
`default_nettype none
interface ftmma_in_if #(
	parameter int unsigned TIME_BITS = 32
);
	logic                 valid;
	logic                 ready;
	logic                 operation;
	logic [TIME_BITS-1:0] frame_time;

	modport source (output valid, output operation, output frame_time, input ready);
	modport sink   (input valid, input operation, input frame_time, output ready);
endinterface
`default_nettype wire

// ----- src/ftmma_out_if.sv -----
// Output channel of the frame-time block: valid/ready with min, max and average.
// Depends on nothing.
`default_nettype none
interface ftmma_out_if #(
	parameter int unsigned TIME_BITS = 32
);
	logic                 valid;
	logic                 ready;
	logic [TIME_BITS-1:0] min_time;
	logic [TIME_BITS-1:0] max_time;
	logic [TIME_BITS-1:0] average_time;

	modport source (output valid, output min_time, output max_time, output average_time,
		input ready);
	modport sink   (input valid, input min_time, input max_time, input average_time,
		output ready);
endinterface
`default_nettype wire

// ----- src/ftmma_front.sv -----
// Front end: accepts input items, classifies the operation and queues them.
// Two-entry queue towards the back end. Uses ftmma_pkg.
`default_nettype none
module ftmma_front
	import ftmma_pkg::*;
#(
	parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 in_operation,
	input  wire logic [TIME_BITS-1:0] in_frame_time,
	output logic                      q_valid,
	input  wire logic                 q_ready,
	output op_t                       q_op,
	output logic [TIME_BITS-1:0]      q_time
);

	op_t                  op_q   [2];
	logic [TIME_BITS-1:0] time_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           cnt_q;
	logic                 push;
	logic                 pop;
	op_t                  in_op;

	assign in_op    = in_operation ? OP_CLEAR : OP_SAMPLE;
	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;
	assign q_op     = op_q[rd_ptr_q];
	assign q_time   = time_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			op_q[wr_ptr_q]   <= in_op;
			time_q[wr_ptr_q] <= in_frame_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_full_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !pop) |=> (cnt_q == 2'd2)) else $error("full queue lost an item");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q)) else $error("queue pointers out of step");
`endif

endmodule
`default_nettype wire

// ----- src/ftmma_div.sv -----
// Restoring divider, one quotient bit per cycle, for the windowed average.
// Quotient is known to fit in TIME_BITS. Uses ftmma_pkg for defaults.
`default_nettype none
module ftmma_div
	import ftmma_pkg::*;
#(
	parameter int unsigned TIME_BITS = TIME_BITS_DEF,
	parameter int unsigned SW        = 38,
	parameter int unsigned CW        = 7
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [SW-1:0]        dividend,
	input  wire logic [CW-1:0]        divisor,
	output logic                      done,
	output logic [TIME_BITS-1:0]      quotient
);

	localparam int unsigned CTW = $clog2(SW + 1);

	logic           busy_q;
	logic           done_q;
	logic [CTW-1:0] cnt_q;
	logic [SW-1:0]  dvd_q;
	logic [CW-1:0]  dsr_q;
	logic [CW-1:0]  rem_q;
	logic [CW:0]    trial;
	logic [CW:0]    diff;
	logic           fits;

	assign trial    = {rem_q, dvd_q[SW-1]};
	assign diff     = trial - {1'b0, dsr_q};
	assign fits     = (trial >= {1'b0, dsr_q});
	assign done     = done_q;
	assign quotient = dvd_q[TIME_BITS-1:0];

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SW-2:0], fits};
			rem_q <= fits ? diff[CW-1:0] : trial[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CTW'(SW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/ftmma_back.sv -----
// Back end: applies samples and clears to the ring, running sum, min and max,
// divides for the average and holds the result register. Uses ftmma_pkg, ftmma_div.
`default_nettype none
module ftmma_back
	import ftmma_pkg::*;
#(
	parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF,
	parameter int unsigned TIME_BITS  = TIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cfg_t                 cfg,
	input  wire logic                 q_valid,
	output logic                      q_ready,
	input  wire op_t                  q_op,
	input  wire logic [TIME_BITS-1:0] q_time,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [TIME_BITS-1:0]      out_min,
	output logic [TIME_BITS-1:0]      out_max,
	output logic [TIME_BITS-1:0]      out_avg
);

	localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
	localparam int unsigned PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int unsigned SW = TIME_BITS + CW;

	back_state_t          state_q, state_d;
	logic [CW-1:0]        win_q;
	logic [CW-1:0]        held_q;
	logic [PW-1:0]        pos_q;
	logic [SW-1:0]        sum_q;
	logic [TIME_BITS-1:0] min_q;
	logic [TIME_BITS-1:0] max_q;
	logic [TIME_BITS-1:0] t_q;
	logic [TIME_BITS-1:0] rd_q;
	logic [TIME_BITS-1:0] avg_q;
	logic [TIME_BITS-1:0] ring [MAX_WINDOW];

	logic                 out_valid_q;
	logic [TIME_BITS-1:0] out_min_q;
	logic [TIME_BITS-1:0] out_max_q;
	logic [TIME_BITS-1:0] out_avg_q;

	logic                 take;
	logic                 div_start;
	logic                 emit_load;
	logic                 div_done;
	logic [TIME_BITS-1:0] div_q;

	logic                 full;
	logic [SW-1:0]        sum_sub;
	logic [SW-1:0]        sum_n;
	logic [CW-1:0]        held_n;
	logic [CW-1:0]        pos_inc;
	logic [PW-1:0]        pos_n;
	logic [31:0]          cfg_v;
	logic [31:0]          cfg_sat;

	// window register value: zero becomes one, saturate at the ring depth
	always_comb begin
		cfg_v = 32'(cfg.value);
		if (cfg_v == 32'd0)
			cfg_sat = 32'd1;
		else if (cfg_v > 32'(MAX_WINDOW))
			cfg_sat = 32'(MAX_WINDOW);
		else
			cfg_sat = cfg_v;
	end

	assign full    = (held_q >= win_q);
	assign sum_sub = full ? (sum_q - SW'(rd_q)) : sum_q;
	assign sum_n   = sum_sub + SW'(t_q);
	assign held_n  = full ? held_q : (held_q + 1'b1);
	assign pos_inc = CW'(pos_q) + 1'b1;
	assign pos_n   = (pos_inc >= win_q) ? '0 : PW'(pos_inc);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid)
					state_d = (q_op == OP_CLEAR) ? ST_EMIT : ST_UPD;
			end
			ST_UPD: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_ready   = (state_q == ST_IDLE);
		take      = q_valid && q_ready;
		div_start = (state_q == ST_UPD);
		emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	end

	ftmma_div #(
		.TIME_BITS (TIME_BITS),
		.SW        (SW),
		.CW        (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_n),
		.divisor  (held_n),
		.done     (div_done),
		.quotient (div_q)
	);

	// ring: registered read at the write position, write during update
	always_ff @(posedge clk) begin
		rd_q <= ring[pos_q];
		if (state_q == ST_UPD)
			ring[pos_q] <= t_q;
	end

	always_ff @(posedge clk) begin
		if (take)
			t_q <= q_time;
		if (take && q_op == OP_CLEAR)
			avg_q <= '0;
		else if (div_done)
			avg_q <= div_q;
		if (emit_load) begin
			out_min_q <= min_q;
			out_max_q <= max_q;
			out_avg_q <= avg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_q       <= CW'(MAX_WINDOW);
			held_q      <= '0;
			pos_q       <= '0;
			sum_q       <= '0;
			min_q       <= '1;
			max_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cfg.we || (take && q_op == OP_CLEAR)) begin
				if (cfg.we)
					win_q <= CW'(cfg_sat);
				held_q <= '0;
				pos_q  <= '0;
				sum_q  <= '0;
				min_q  <= '1;
				max_q  <= '0;
			end else if (state_q == ST_UPD) begin
				held_q <= held_n;
				pos_q  <= pos_n;
				sum_q  <= sum_n;
				if (t_q < min_q)
					min_q <= t_q;
				if (t_q > max_q)
					max_q <= t_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_min   = out_min_q;
	assign out_max   = out_max_q;
	assign out_avg   = out_avg_q;

`ifndef NO_ASSERTIONS
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= win_q) else $error("sample count above window");
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(pos_q) < win_q) else $error("write position outside window");
	a_min_max: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q != '0) |-> (min_q <= max_q)) else $error("min above max");
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV)) else $error("divider done outside divide");
`endif

endmodule
`default_nettype wire

// ----- src/frame_time_min_max_average_top.sv -----
// Frame-time statistics: min, max and windowed average of frame-time samples.
// Input item: operation (0 = sample, 1 = clear) and frame_time, on in_ch.
// Result item: min_time, max_time, average_time after the item, on out_ch.
// Every input item gives exactly one result item, in order.
// window_size_we / window_size set the averaging window (0 taken as 1,
// saturated at MAX_WINDOW) and clear all statistics; write only while idle.
// A sample passes from the head of the input queue through update, the
// bit-serial divider over SW = TIME_BITS + clog2(MAX_WINDOW + 1) bits (39
// at defaults) and emit to the result register; a clear goes straight to emit.
// One item at a time.
// A two-entry input queue takes items while a result waits, and the result
// register holds until out_ch.ready; the back end stalls behind it.
// Reset: window MAX_WINDOW, min all ones, max and sum zero; the
// ring needs no clearing pass since only entries written since the last
// clear are ever read.
// Uses ftmma_pkg, ftmma_in_if, ftmma_out_if, ftmma_front, ftmma_back.
`default_nettype none
module frame_time_min_max_average_top
	import ftmma_pkg::*;
#(
	parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF,
	parameter int unsigned TIME_BITS  = TIME_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                window_size_we,
	input  wire logic [CFG_BITS-1:0] window_size,
	ftmma_in_if.sink                 in_ch,
	ftmma_out_if.source              out_ch
);

	cfg_t                 cfg;
	logic                 q_valid;
	logic                 q_ready;
	op_t                  q_op;
	logic [TIME_BITS-1:0] q_time;

	assign cfg.we    = window_size_we;
	assign cfg.value = window_size;

	ftmma_front #(
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_ch.valid),
		.in_ready      (in_ch.ready),
		.in_operation  (in_ch.operation),
		.in_frame_time (in_ch.frame_time),
		.q_valid       (q_valid),
		.q_ready       (q_ready),
		.q_op          (q_op),
		.q_time        (q_time)
	);

	ftmma_back #(
		.MAX_WINDOW (MAX_WINDOW),
		.TIME_BITS  (TIME_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_op      (q_op),
		.q_time    (q_time),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_min   (out_ch.min_time),
		.out_max   (out_ch.max_time),
		.out_avg   (out_ch.average_time)
	);

endmodule
`default_nettype wire
